FILE: rtl/avd_pkg.sv
// Shared widths, codes and controller/datapath command types for the voltmeter display.
package avd_pkg;

   localparam int DIGITS        = 4;
   localparam int CMD_W         = 1;
   localparam int SAMPLE_W      = 10;
   localparam int REF_W         = 13;
   localparam int GAIN_W        = 16;
   localparam int DIGIT_W       = 4;
   localparam int SEL_W         = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   // sample * ref_mV needs 23 bits, times the Q8.8 gain 39 bits.
   localparam int PROD_W        = SAMPLE_W + REF_W;
   localparam int UNITS_W       = PROD_W + GAIN_W;
   // One volt is 1000 * 2^18 units, so units >> 18 counts millivolts.
   localparam int VOLT_SHIFT    = 18;
   localparam int QUANT_W       = UNITS_W - VOLT_SHIFT;
   localparam int BCD_DIGITS    = 7;
   localparam int BCD_W         = BCD_DIGITS * DIGIT_W;
   localparam int BITS_PER_STEP = 3;
   localparam int BCD_STEPS     = QUANT_W / BITS_PER_STEP;
   localparam int STEP_W        = 3;

   localparam logic [REF_W-1:0]  REF_RESET  = 13'd5010;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   localparam logic [CSR_INDEX_W-1:0] REG_REF_MV   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIV_GAIN = 2'd1;

   localparam logic [SEL_W-1:0] SLOT_ONES      = 2'd0;
   localparam logic [SEL_W-1:0] SLOT_TENS      = 2'd1;
   localparam logic [SEL_W-1:0] SLOT_HUNDREDS  = 2'd2;
   localparam logic [SEL_W-1:0] SLOT_THOUSANDS = 2'd3;

   localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
   localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_code_type;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic capture;
      logic mul_first;
      logic mul_second;
      logic bcd_load;
      logic bcd_step;
      logic commit;
      logic tick;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_blocked;
   } dp_status_type;

endpackage

FILE: rtl/avd_ifs.sv
// Valid/ready channel interfaces for the request, result and register-write ports.
interface avd_req_if;
   logic                           valid;
   logic                           ready;
   logic [avd_pkg::CMD_W-1:0]      cmd;
   logic [avd_pkg::SAMPLE_W-1:0]   sample;
   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface avd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [avd_pkg::DIGIT_W-1:0]    digit_value;
   logic [avd_pkg::SEL_W-1:0]      digit_select;
   logic                           decimal_point;
   modport source (output valid, output digit_value, output digit_select,
                   output decimal_point, input ready);
   modport sink   (input valid, input digit_value, input digit_select,
                   input decimal_point, output ready);
endinterface

interface avd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [avd_pkg::CSR_INDEX_W-1:0]  index;
   logic [avd_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/avd_ctrl.sv
// Controller state machine that sequences a sample conversion and handles scan ticks.
module avd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [avd_pkg::CMD_W-1:0]  req_cmd,
   output logic                       req_ready,
   input  avd_pkg::dp_status_type     status,
   output avd_pkg::dp_cmd_type        command
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_FIRST,
      ST_MUL_SECOND,
      ST_BCD_LOAD,
      ST_BCD_RUN,
      ST_COMMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic [avd_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                          accept;

   localparam logic [avd_pkg::STEP_W-1:0] LAST_STEP =
      avd_pkg::STEP_W'(avd_pkg::BCD_STEPS - 1);

   // A tick needs the result register; a sample does not.
   assign req_ready = (state_ff == ST_IDLE) &&
                      ((req_cmd == avd_pkg::CMD_SAMPLE) || !status.rsp_blocked);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      command  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == avd_pkg::CMD_TICK) begin
                  command.tick = 1'b1;
               end else begin
                  command.capture = 1'b1;
                  state_in        = ST_MUL_FIRST;
               end
            end
         end
         ST_MUL_FIRST: begin
            command.mul_first = 1'b1;
            state_in          = ST_MUL_SECOND;
         end
         ST_MUL_SECOND: begin
            command.mul_second = 1'b1;
            state_in           = ST_BCD_LOAD;
         end
         ST_BCD_LOAD: begin
            command.bcd_load = 1'b1;
            step_in          = '0;
            state_in         = ST_BCD_RUN;
         end
         ST_BCD_RUN: begin
            command.bcd_step = 1'b1;
            step_in          = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            command.commit = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // A sample transfer always leads into the first multiply.
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      command.capture |=> state_ff == ST_MUL_FIRST)
      else $error("sample accepted without starting conversion");

   // The conversion runs exactly the planned number of steps.
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BCD_RUN && step_ff == LAST_STEP) |=> state_ff == ST_COMMIT)
      else $error("digit conversion did not end on its last step");

   // Nothing is taken while a conversion is in flight.
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request ready during conversion");

endmodule

FILE: rtl/avd_dp.sv
// Datapath: registers, two multiplies, digit conversion, digit store and scan output.
module avd_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  avd_pkg::dp_cmd_type               command,
   output avd_pkg::dp_status_type            status,
   input  logic [avd_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                              csr_valid,
   input  logic [avd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [avd_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              csr_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [avd_pkg::DIGIT_W-1:0]       digit_value,
   output logic [avd_pkg::SEL_W-1:0]         digit_select,
   output logic                              decimal_point
);

   logic [avd_pkg::REF_W-1:0]     ref_ff, ref_in;
   logic [avd_pkg::GAIN_W-1:0]    gain_ff, gain_in;
   logic [avd_pkg::SAMPLE_W-1:0]  sample_ff;
   logic [avd_pkg::PROD_W-1:0]    prod_ff;
   logic [avd_pkg::UNITS_W-1:0]   units_ff;
   logic [avd_pkg::QUANT_W-1:0]   bin_ff, bin_in;
   logic [avd_pkg::BCD_W-1:0]     bcd_ff, bcd_in, bcd_next;
   avd_pkg::digit_type            digits_ff [avd_pkg::DIGITS];
   avd_pkg::digit_type            digits_in [avd_pkg::DIGITS];
   logic                          mid_ff, mid_in;
   logic [avd_pkg::SEL_W-1:0]     scan_ff, scan_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [avd_pkg::DIGIT_W-1:0]   rsp_value_ff;
   logic [avd_pkg::SEL_W-1:0]     rsp_select_ff;
   logic                          rsp_point_ff, point_in;
   avd_pkg::digit_type            bcd_digit [avd_pkg::BCD_DIGITS];
   logic                          over_range;

   function automatic logic [avd_pkg::BCD_W-1:0] dabble_shift(
      input logic [avd_pkg::BCD_W-1:0] bcd,
      input logic                      bit_in);
      logic [avd_pkg::BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < avd_pkg::BCD_DIGITS; d++) begin
         if (adj[d*avd_pkg::DIGIT_W +: avd_pkg::DIGIT_W] >= 4'd5) begin
            adj[d*avd_pkg::DIGIT_W +: avd_pkg::DIGIT_W] =
               adj[d*avd_pkg::DIGIT_W +: avd_pkg::DIGIT_W] + 4'd3;
         end
      end
      return {adj[avd_pkg::BCD_W-2:0], bit_in};
   endfunction

   assign csr_ready = 1'b1;
   assign status.rsp_blocked = rsp_valid_ff && !rsp_ready;

   always_comb begin
      ref_in  = ref_ff;
      gain_in = gain_ff;
      if (csr_valid) begin
         unique case (csr_index)
            avd_pkg::REG_REF_MV:   ref_in  = csr_data[avd_pkg::REF_W-1:0];
            avd_pkg::REG_DIV_GAIN: gain_in = csr_data[avd_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Three bits of the double-dabble conversion per cycle.
   always_comb begin
      bcd_next = bcd_ff;
      for (int k = 0; k < avd_pkg::BITS_PER_STEP; k++) begin
         bcd_next = dabble_shift(bcd_next, bin_ff[avd_pkg::QUANT_W-1-k]);
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (command.bcd_load) begin
         bin_in = units_ff[avd_pkg::UNITS_W-1:avd_pkg::VOLT_SHIFT];
         bcd_in = '0;
      end else if (command.bcd_step) begin
         bin_in = {bin_ff[avd_pkg::QUANT_W-avd_pkg::BITS_PER_STEP-1:0],
                   {avd_pkg::BITS_PER_STEP{1'b0}}};
         bcd_in = bcd_next;
      end
   end

   // Millivolt count in decimal: mid range keeps millivolts / 10, over range shows all nines, else / 100.
   always_comb begin
      for (int d = 0; d < avd_pkg::BCD_DIGITS; d++) begin
         bcd_digit[d] = bcd_ff[d*avd_pkg::DIGIT_W +: avd_pkg::DIGIT_W];
      end
      over_range = bcd_digit[6] != avd_pkg::DIGIT_ZERO;
      mid_in = !over_range && bcd_digit[5] == avd_pkg::DIGIT_ZERO &&
               bcd_digit[4] == avd_pkg::DIGIT_ZERO && bcd_digit[3] != avd_pkg::DIGIT_ZERO;
      for (int d = 0; d < avd_pkg::DIGITS; d++) begin
         if (over_range) begin
            digits_in[d] = avd_pkg::DIGIT_NINE;
         end else if (mid_in) begin
            digits_in[d] = (d == avd_pkg::DIGITS - 1) ? avd_pkg::DIGIT_ZERO
                                                      : bcd_digit[d+1];
         end else begin
            digits_in[d] = bcd_digit[d+2];
         end
      end
   end

   always_comb begin
      case (scan_ff)
         avd_pkg::SLOT_TENS:     point_in = !mid_ff;
         avd_pkg::SLOT_HUNDREDS: point_in = mid_ff;
         default:                point_in = 1'b0;
      endcase
      scan_in      = scan_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (command.tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff       <= avd_pkg::REF_RESET;
         gain_ff      <= avd_pkg::GAIN_RESET;
         mid_ff       <= 1'b0;
         scan_ff      <= avd_pkg::SLOT_ONES;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < avd_pkg::DIGITS; d++) begin
            digits_ff[d] <= avd_pkg::DIGIT_ZERO;
         end
      end else begin
         ref_ff       <= ref_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (command.commit) begin
            mid_ff <= mid_in;
            for (int d = 0; d < avd_pkg::DIGITS; d++) begin
               digits_ff[d] <= digits_in[d];
            end
         end
         if (command.tick) begin
            scan_ff <= scan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (command.capture) begin
         sample_ff <= req_sample;
      end
      if (command.mul_first) begin
         prod_ff <= {{avd_pkg::REF_W{1'b0}}, sample_ff} *
                    {{avd_pkg::SAMPLE_W{1'b0}}, ref_ff};
      end
      if (command.mul_second) begin
         units_ff <= {{avd_pkg::GAIN_W{1'b0}}, prod_ff} *
                     {{avd_pkg::PROD_W{1'b0}}, gain_ff};
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      if (command.tick) begin
         rsp_value_ff  <= digits_ff[scan_ff];
         rsp_select_ff <= avd_pkg::SLOT_THOUSANDS - scan_ff;
         rsp_point_ff  <= point_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign digit_value   = rsp_value_ff;
   assign digit_select  = rsp_select_ff;
   assign decimal_point = rsp_point_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      command.tick |-> (!rsp_valid_ff || rsp_ready))
      else $error("scan result overwritten before transfer");

   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      command.tick |=> scan_ff == avd_pkg::SEL_W'($past(scan_ff) + 2'd1))
      else $error("scan position did not advance on tick");

   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      command.commit |=> (digits_ff[0] <= avd_pkg::DIGIT_NINE &&
                          digits_ff[1] <= avd_pkg::DIGIT_NINE &&
                          digits_ff[2] <= avd_pkg::DIGIT_NINE &&
                          digits_ff[3] <= avd_pkg::DIGIT_NINE))
      else $error("stored digit is not decimal");

endmodule

FILE: rtl/autorange_voltmeter_display.sv
// A scan tick's digit is shown in the cycle after the tick is taken.
// A sample holds the request side through its transfer, two multiplies, a load, seven 3-bit
// conversion steps of the shared double-dabble unit, and a store.
// One tick per cycle while the result side keeps up; no request is taken during a sample.
// Reset is synchronous and active high: digits clear to zero, the range to below one volt,
// the scan to the ones digit, and the registers to 5010 mV and unity gain.
module autorange_voltmeter_display (
   input  logic       clock,
   input  logic       reset,
   avd_req_if.sink    req_chan,
   avd_rsp_if.source  rsp_chan,
   avd_csr_if.sink    csr_chan
);

   // The controller and the datapath talk only through these two structs.
   avd_pkg::dp_cmd_type    command;
   avd_pkg::dp_status_type status;

   // The controller owns request acceptance: ticks pass unless the result stalls, samples start
   // a conversion sequence that holds off further requests until the digits are stored.
   avd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .status    (status),
      .command   (command)
   );

   // The datapath holds the configuration, the arithmetic, the digit store and the
   // result register. The result register frees the request side, so a tick can be
   // taken in the same cycle as the previous digit's transfer.
   avd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .command       (command),
      .status        (status),
      .req_sample    (req_chan.sample),
      .csr_valid     (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .csr_ready     (csr_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .digit_value   (rsp_chan.digit_value),
      .digit_select  (rsp_chan.digit_select),
      .decimal_point (rsp_chan.decimal_point)
   );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the autoranging voltmeter with its multiplexed digit scan.
`timescale 1ns / 1ps

module tb_top;
   import avd_pkg::*;

   // A sample keeps the converter busy after its transfer and returns nothing,
   // so register writes first wait out the BUSY_SETTLE delay.
   localparam int unsigned BUSY_SETTLE     = 16;
   localparam int unsigned TAIL_CYCLES     = 20;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned STALL_LIMIT     = 3000;
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned PHASE_ITEMS     = 190;

   // Register indexes past the end of the map; writes to them must be dropped.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

   // Voltage thresholds in units of sample * ref_mV * gain (Q8.8).
   localparam bit [63:0] ONE_VOLT    = 64'd262144000;
   localparam bit [63:0] TEN_VOLT    = 64'd2621440000;
   localparam bit [63:0] MAX_READING = 64'd9999;

   typedef struct packed {
      digit_type        value;
      logic [SEL_W-1:0] select;
      logic             point;
   } scan_digit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   avd_req_if req_bus ();
   avd_rsp_if rsp_bus ();
   avd_csr_if csr_bus ();

   autorange_voltmeter_display uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #2 clock = ~clock;

   // Shadow of the block: registers, the stored digits, the range flag and
   // the scan position, all updated when the matching transfer is seen.
   logic [REF_W-1:0]  model_ref_mv = REF_RESET;
   logic [GAIN_W-1:0] model_gain   = GAIN_RESET;
   digit_type         held_digits [DIGITS];
   logic              two_decimals = 1'b0;
   logic [SEL_W-1:0]  scan_slot    = SLOT_ONES;

   // Digits that the scan still owes us, oldest first.
   scan_digit_type pending_digits [$];

   int unsigned mismatches = 0;
   int unsigned items_sent = 0;

   // Sender burst control.
   bit          gaps_enabled = 1'b1;
   int unsigned burst_left   = 0;

   // Receiver stall control. A test asks for a long hold-off through
   // hold_off_request, and the receiver counts it down on its own.
   int unsigned hold_off_request = 0;
   int unsigned hold_left        = 0;
   int unsigned pattern_age      = 0;
   logic [7:0]  ready_pattern    = 8'hFF;
   logic [2:0]  pattern_phase    = 3'd0;

   int unsigned quiet_cycles = 0;

   initial begin
      foreach (held_digits[i]) held_digits[i] = DIGIT_ZERO;
   end

   // A new reading: scale it exactly, choose the range, truncate, clamp to
   // four digits and store them ones first.
   function automatic void latch_reading(input logic [SAMPLE_W-1:0] reading);
      bit [63:0] units;
      bit [63:0] shown;
      units = 64'(reading) * 64'(model_ref_mv) * 64'(model_gain);
      two_decimals = (units >= ONE_VOLT) && (units < TEN_VOLT);
      if (two_decimals) begin
         shown = units / (ONE_VOLT / 100);
      end else begin
         shown = units / (ONE_VOLT / 10);
      end
      if (shown > MAX_READING) begin
         shown = MAX_READING;
      end
      for (int i = 0; i < DIGITS; i++) begin
         held_digits[i] = digit_type'(shown % 10);
         shown = shown / 10;
      end
   endfunction

   // A scan tick: the digit at the current slot, its select code and point.
   function automatic scan_digit_type next_scan_digit();
      scan_digit_type d;
      d.value  = held_digits[scan_slot];
      d.select = SLOT_THOUSANDS - scan_slot;
      if (scan_slot == SLOT_TENS) begin
         d.point = ~two_decimals;
      end else if (scan_slot == SLOT_HUNDREDS) begin
         d.point = two_decimals;
      end else begin
         d.point = 1'b0;
      end
      scan_slot = scan_slot + 1'b1;
      return d;
   endfunction

   // Readings are biased toward the extremes and toward the one-volt and
   // ten-volt thresholds of the current register setting.
   function automatic logic [SAMPLE_W-1:0] pick_reading();
      bit [63:0]   per_count;
      bit [63:0]   cut;
      int unsigned choice;
      choice = $urandom_range(0, 9);
      per_count = 64'(model_ref_mv) * 64'(model_gain);
      if (choice == 0) return '0;
      if (choice == 1) return '1;
      if (choice <= 4 && per_count != 0) begin
         cut = ((choice <= 2) ? ONE_VOLT : TEN_VOLT) / per_count;
         cut = cut + $urandom_range(0, 2);
         if (cut > 0) cut = cut - 1;
         if (cut < 1024) return SAMPLE_W'(cut);
      end
      return SAMPLE_W'($urandom_range(0, 1023));
   endfunction

   // Offers one request and waits for its transfer. Requests come in bursts
   // of random length; between bursts, while gaps are enabled, valid drops for a random gap.
   task automatic send_request(input cmd_code_type cmd, input logic [SAMPLE_W-1:0] reading);
      if (burst_left == 0) begin
         if (gaps_enabled) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid  <= 1'b1;
      req_bus.cmd    <= cmd;
      req_bus.sample <= reading;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      if (cmd == CMD_TICK) begin
         pending_digits.push_back(next_scan_digit());
      end else begin
         latch_reading(reading);
      end
   endtask

   // Stops requests, waits for every owed digit, then lets a possible sample
   // in flight finish before anything touches the registers.
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (BUSY_SETTLE) @(posedge clock);
   endtask

   // One register transfer. Valid stays high so that writes can follow
   // back to back; the caller lowers it.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         REG_REF_MV:   model_ref_mv = data[REF_W-1:0];
         REG_DIV_GAIN: model_gain   = data[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [CSR_DATA_W-1:0] ref_word,
                                input logic [CSR_DATA_W-1:0] gain_word,
                                input bit with_spares);
      drain_block();
      write_register(REG_REF_MV, ref_word);
      write_register(REG_DIV_GAIN, gain_word);
      if (with_spares) begin
         write_register(REG_SPARE_2, CSR_DATA_W'($urandom));
         write_register(REG_SPARE_3, CSR_DATA_W'($urandom));
      end
      csr_bus.valid <= 1'b0;
   endtask

   // A reading followed by the given number of scan ticks; four of them show all four stored digits.
   task automatic reading_then_scan(input logic [SAMPLE_W-1:0] reading, input int unsigned ticks);
      send_request(CMD_SAMPLE, reading);
      repeat (ticks) send_request(CMD_TICK, SAMPLE_W'($urandom));
   endtask

   // Out of reset the display holds zeros in the one-decimal range.
   task automatic test_reset_state();
      repeat (DIGITS) send_request(CMD_TICK, SAMPLE_W'($urandom));
   endtask

   // Exactly one volt is mid range and exactly ten volts is not; one count
   // below one volt falls back to one decimal.
   task automatic test_range_edges();
      set_registers(16'd1000, 16'd512, 1'b0);
      reading_then_scan(10'd512, DIGITS);
      reading_then_scan(10'd511, DIGITS);
      set_registers(16'd1000, 16'd5120, 1'b0);
      reading_then_scan(10'd512, DIGITS);
   endtask

   // Largest reference, gain and reading saturate at 9999. The writes to
   // the spare indexes in between must not disturb either register.
   task automatic test_overrange_and_spare_registers();
      set_registers(16'd8191, 16'd65535, 1'b1);
      reading_then_scan(10'd1023, DIGITS);
   endtask

   // A zero reference (bit 13 set, masked off) or a zero gain reads zero.
   task automatic test_zero_scale();
      set_registers(16'h2000, 16'd256, 1'b0);
      reading_then_scan(10'd1023, 2);
      set_registers(16'd5010, 16'd0, 1'b0);
      reading_then_scan(10'd1023, 2);
   endtask

   task automatic randomize_registers();
      logic [CSR_DATA_W-1:0] ref_word;
      logic [CSR_DATA_W-1:0] gain_word;
      case ($urandom_range(0, 5))
         0:       ref_word = 16'd1000;
         1:       ref_word = 16'd8191;
         2:       ref_word = CSR_DATA_W'($urandom);
         default: ref_word = CSR_DATA_W'($urandom_range(1000, 8191));
      endcase
      case ($urandom_range(0, 5))
         0:       gain_word = 16'd1;
         1:       gain_word = 16'd65535;
         2:       gain_word = CSR_DATA_W'($urandom);
         default: gain_word = CSR_DATA_W'($urandom_range(1, 65535) >> $urandom_range(0, 12));
      endcase
      set_registers(ref_word, gain_word, $urandom_range(0, 3) == 0);
   endtask

   // Mostly a reading followed by a full scan, with some loose runs of
   // random commands that leave the scan part way through.
   task automatic test_random_traffic();
      int unsigned start;
      int unsigned run;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         randomize_registers();
         gaps_enabled = ($urandom_range(0, 3) != 0);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
               reading_then_scan(pick_reading(), DIGITS);
            end else begin
               run = $urandom_range(1, 3);
               repeat (run) send_request(cmd_code_type'($urandom_range(0, 1)), pick_reading());
            end
         end
      end
      gaps_enabled = 1'b1;
   endtask

   // The receiver holds off for a long stretch while ticks keep coming
   // with no gaps, so the block has to stall its request side.
   task automatic test_output_backpressure();
      send_request(CMD_SAMPLE, pick_reading());
      gaps_enabled = 1'b0;
      hold_off_request = HOLD_OFF_CYCLES;
      repeat (64) send_request(CMD_TICK, SAMPLE_W'($urandom));
      gaps_enabled = 1'b1;
   endtask

   initial begin
      req_bus.valid  = 1'b0;
      req_bus.cmd    = CMD_SAMPLE;
      req_bus.sample = '0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = REG_REF_MV;
      csr_bus.data   = '0;
      rsp_bus.ready  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_range_edges();
      test_overrange_and_spare_registers();
      test_zero_scale();
      test_random_traffic();
      test_output_backpressure();

      // Let the last digits drain, then give the block its latency once more
      // so that any stray result still shows up.
      req_bus.valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Receiver: a random eight-bit ready pattern that is replaced at random, sometimes
   // with all ones, plus the long hold-off on request.
   always @(posedge clock) begin
      if (hold_off_request != 0) begin
         hold_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            pattern_age = $urandom_range(16, 96);
            ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         end
         pattern_age--;
         rsp_bus.ready <= ready_pattern[pattern_phase];
         pattern_phase = pattern_phase + 1'b1;
      end
   end

   // Every result transfer is matched against the oldest owed digit.
   always @(posedge clock) begin : check_digits
      scan_digit_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_digits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected digit transfer: digit %0d select %0d point %0b",
                        rsp_bus.digit_value, rsp_bus.digit_select, rsp_bus.decimal_point);
            end
         end else begin
            want = pending_digits.pop_front();
            if (rsp_bus.digit_value !== want.value || rsp_bus.digit_select !== want.select ||
                rsp_bus.decimal_point !== want.point) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b (value/select/point)",
                           want.value, want.select, want.point, rsp_bus.digit_value,
                           rsp_bus.digit_select, rsp_bus.decimal_point);
               end
            end
         end
      end
   end

   // Watchdog: too many cycles in a row without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
